/* hw/rtl/gdn_pkg.sv */
// Package for the Gregorian day-number calendar: codes, states, constants and tables.
// Used by gdn_years, gregorian_day_number_calendar, gdn_checker and the testbench; depends on nothing.
package gdn_pkg;

    localparam int MAX_YEAR = 999999;

    // Day number of the last day of MAX_YEAR.
    localparam int LAST_DAY = MAX_YEAR * 365 + MAX_YEAR / 4 - MAX_YEAR / 100
                              + MAX_YEAR / 400 - MAX_YEAR / 4000;

    localparam logic [8:0] DAYS_LONG_YEAR = 9'd366;

    // Reciprocals for exact division of a 20-bit year by 100, 400 and 4000,
    // and of a 30-bit month count by 12.
    localparam logic [30:0] RECIP_100  = 31'd1342178;
    localparam logic [30:0] RECIP_400  = 31'd1342178;
    localparam logic [30:0] RECIP_4000 = 31'd1073742;
    localparam logic [30:0] RECIP_12   = 31'd1431655766;
    localparam logic [30:0] DAYS_PER_YEAR = 31'd365;

    localparam logic [2:0] CMD_GOTO  = 3'd0;
    localparam logic [2:0] CMD_ADDD  = 3'd1;
    localparam logic [2:0] CMD_ADDM  = 3'd2;
    localparam logic [2:0] CMD_ADDY  = 3'd3;
    localparam logic [2:0] CMD_READ  = 3'd4;

    localparam logic [3:0] LAST_MONTH = 4'd11;
    localparam logic [3:0] FEBRUARY   = 4'd1;

    typedef enum logic [0:0] {
        OP_DIY,
        OP_DIV12
    } t_eng_op;

    typedef struct packed {
        logic        start;
        t_eng_op     op;
        logic [29:0] arg;
    } t_eng_req;

    typedef struct packed {
        logic        done;
        logic [28:0] res;
    } t_eng_rsp;

    typedef enum logic [2:0] {
        E_IDLE,
        E_Q100,
        E_Q400,
        E_Q4000,
        E_M365,
        E_SUM,
        E_D12,
        E_D12R
    } t_eng_st;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DEC,
        S_DIVW,
        S_YCHK,
        S_DAW,
        S_DBW,
        S_RANGE,
        S_BS,
        S_BSW,
        S_R1W,
        S_R2W,
        S_MON,
        S_COMMIT,
        S_FIN
    } t_state;

    function automatic logic [4:0] month_len(input logic [3:0] m);
        logic [4:0] len;
        case (m)
            4'd1:                      len = 5'd28;
            4'd3, 4'd5, 4'd8, 4'd10:   len = 5'd30;
            default:                   len = 5'd31;
        endcase
        return len;
    endfunction

    function automatic logic [8:0] month_start(input logic [3:0] m);
        logic [8:0] s;
        case (m)
            4'd0:    s = 9'd0;
            4'd1:    s = 9'd31;
            4'd2:    s = 9'd59;
            4'd3:    s = 9'd90;
            4'd4:    s = 9'd120;
            4'd5:    s = 9'd151;
            4'd6:    s = 9'd181;
            4'd7:    s = 9'd212;
            4'd8:    s = 9'd243;
            4'd9:    s = 9'd273;
            4'd10:   s = 9'd304;
            default: s = 9'd334;
        endcase
        return s;
    endfunction

    // Remainder modulo 7, using 8 = 1 (mod 7) to fold octal digits.
    function automatic logic [2:0] mod7(input logic [28:0] v);
        logic [6:0] s1;
        logic [3:0] s2;
        logic [3:0] s3;
        s1 = 7'(v[28:27]);
        for (int i = 0; i < 9; i++) begin
            s1 = s1 + 7'(v[3 * i +: 3]);
        end
        s2 = 4'(s1[2:0]) + 4'(s1[5:3]) + 4'(s1[6]);
        s3 = 4'(s2[2:0]) + 4'(s2[3]);
        if (s3 >= 4'd7) begin
            s3 = s3 - 4'd7;
        end
        return s3[2:0];
    endfunction

endpackage

/* hw/rtl/gregorian_day_number_calendar.sv */
// Gregorian day-number calendar. A read or unknown command answers from the current date, a
// refused move once a range check fails, and a successful move after the year is found by up to 20
// binary-search probes, each a days-in-years evaluation on the shared multiplier.
// One item is in work at a time; the next is accepted the cycle after a result is loaded,
// and output stalls, which keep the result register full, hold it back.
// Reset (synchronous, active low) sets day 1, year 1 January 1. Depends on gdn_pkg, gdn_years.
module gregorian_day_number_calendar
    import gdn_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [2:0]         i_cmd,
    input  logic [19:0]        i_target_year,
    input  logic [3:0]         i_target_month,
    input  logic [4:0]         i_target_day,
    input  logic signed [29:0] i_amount,
    output logic               o_valid,
    input  logic               i_stall,
    output logic               o_ok,
    output logic [19:0]        o_year,
    output logic [3:0]         o_month,
    output logic [4:0]         o_day,
    output logic [28:0]        o_day_number,
    output logic [2:0]         o_weekday
);

    // Control and the current date, all with reset.
    t_state      r_state, n_state;
    t_eng_req    r_req, n_req;
    logic        r_ov, n_ov;
    logic [28:0] r_dn, n_dn;
    logic [19:0] r_year, n_year;
    logic [3:0]  r_month, n_month;
    logic [4:0]  r_day, n_day;
    logic [2:0]  r_wd, n_wd;

    // Working registers of one item and the result register, no reset.
    logic [2:0]         r_cmd, n_cmd;
    logic signed [29:0] r_amt, n_amt;
    logic signed [31:0] r_yt, n_yt;
    logic [3:0]         r_mo, n_mo;
    logic [4:0]         r_tdd, n_tdd;
    logic               r_neg, n_neg;
    logic [29:0]        r_n, n_n;
    logic [28:0]        r_da, n_da;
    logic signed [31:0] r_t, n_t;
    logic [19:0]        r_lo, n_lo;
    logic [19:0]        r_hi, n_hi;
    logic [19:0]        r_mid, n_mid;
    logic [28:0]        r_dlo, n_dlo;
    logic [8:0]         r_rem, n_rem;
    logic               r_leap, n_leap;
    logic [3:0]         r_m, n_m;
    logic               r_ok, n_ok;
    logic               r_o_ok, n_o_ok;
    logic [19:0]        r_o_year, n_o_year;
    logic [3:0]         r_o_month, n_o_month;
    logic [4:0]         r_o_day, n_o_day;
    logic [28:0]        r_o_dn, n_o_dn;
    logic [2:0]         r_o_wd, n_o_wd;

    t_eng_rsp eng_rsp;

    logic               in_acc;
    logic signed [31:0] mi;
    logic [26:0]        q;
    logic [29:0]        q12;
    logic [3:0]         rem12;
    logic signed [31:0] yo;
    logic [20:0]        mid_sum;
    logic [4:0]         len;
    logic [8:0]         span;

    gdn_years u_years (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (r_req),
        .o_rsp   (eng_rsp)
    );

    assign o_stall = (r_state != S_IDLE);
    assign in_acc  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_req   <= '{start: 1'b0, op: OP_DIY, arg: 30'd0};
            r_ov    <= 1'b0;
            r_dn    <= 29'd1;
            r_year  <= 20'd1;
            r_month <= 4'd0;
            r_day   <= 5'd1;
            r_wd    <= 3'd1;
        end else begin
            r_state <= n_state;
            r_req   <= n_req;
            r_ov    <= n_ov;
            r_dn    <= n_dn;
            r_year  <= n_year;
            r_month <= n_month;
            r_day   <= n_day;
            r_wd    <= n_wd;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd     <= n_cmd;
        r_amt     <= n_amt;
        r_yt      <= n_yt;
        r_mo      <= n_mo;
        r_tdd     <= n_tdd;
        r_neg     <= n_neg;
        r_n       <= n_n;
        r_da      <= n_da;
        r_t       <= n_t;
        r_lo      <= n_lo;
        r_hi      <= n_hi;
        r_mid     <= n_mid;
        r_dlo     <= n_dlo;
        r_rem     <= n_rem;
        r_leap    <= n_leap;
        r_m       <= n_m;
        r_ok      <= n_ok;
        r_o_ok    <= n_o_ok;
        r_o_year  <= n_o_year;
        r_o_month <= n_o_month;
        r_o_day   <= n_o_day;
        r_o_dn    <= n_o_dn;
        r_o_wd    <= n_o_wd;
    end

    always_comb begin
        n_state   = r_state;
        n_req     = r_req;
        n_req.start = 1'b0;
        n_ov      = r_ov;
        n_dn      = r_dn;
        n_year    = r_year;
        n_month   = r_month;
        n_day     = r_day;
        n_wd      = r_wd;
        n_cmd     = r_cmd;
        n_amt     = r_amt;
        n_yt      = r_yt;
        n_mo      = r_mo;
        n_tdd     = r_tdd;
        n_neg     = r_neg;
        n_n       = r_n;
        n_da      = r_da;
        n_t       = r_t;
        n_lo      = r_lo;
        n_hi      = r_hi;
        n_mid     = r_mid;
        n_dlo     = r_dlo;
        n_rem     = r_rem;
        n_leap    = r_leap;
        n_m       = r_m;
        n_ok      = r_ok;
        n_o_ok    = r_o_ok;
        n_o_year  = r_o_year;
        n_o_month = r_o_month;
        n_o_day   = r_o_day;
        n_o_dn    = r_o_dn;
        n_o_wd    = r_o_wd;

        // The month sum for add months, split later by floor division by 12.
        mi      = 32'(signed'({1'b0, r_month})) + 32'(r_amt);
        q       = eng_rsp.res[26:0];
        q12     = 30'({q, 3'b000}) + 30'({q, 2'b00});
        rem12   = 4'(r_n - q12);
        yo      = r_neg ? (-32'(signed'({1'b0, q})) - 32'sd1) : 32'(signed'({1'b0, q}));
        mid_sum = 21'(r_lo) + 21'(r_hi) + 21'd1;
        len     = month_len(r_m) + ((r_m == FEBRUARY && r_leap) ? 5'd1 : 5'd0);
        span    = 9'(eng_rsp.res - r_dlo);

        // The result register empties when the far side takes the item.
        if (r_ov && !i_stall) begin
            n_ov = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_cmd   = i_cmd;
                    n_amt   = i_amount;
                    n_yt    = 32'(signed'({1'b0, i_target_year}));
                    n_mo    = i_target_month;
                    n_tdd   = i_target_day;
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                n_ok = 1'b0;
                case (r_cmd)
                    CMD_GOTO: begin
                        n_state = (r_mo > LAST_MONTH) ? S_FIN : S_YCHK;
                    end
                    CMD_ADDD: begin
                        n_t     = 32'(signed'({1'b0, r_dn})) + 32'(r_amt);
                        n_state = S_RANGE;
                    end
                    CMD_ADDM: begin
                        // For a negative sum, divide its complement -mi-1 instead.
                        n_neg     = mi[31];
                        n_n       = mi[31] ? 30'(~mi) : 30'(mi);
                        n_req     = '{start: 1'b1, op: OP_DIV12,
                                      arg: (mi[31] ? 30'(~mi) : 30'(mi))};
                        n_state   = S_DIVW;
                    end
                    CMD_ADDY: begin
                        n_yt    = 32'(signed'({1'b0, r_year})) + 32'(r_amt);
                        n_mo    = 4'd0;
                        n_tdd   = 5'd1;
                        n_state = S_YCHK;
                    end
                    CMD_READ: begin
                        n_ok    = 1'b1;
                        n_state = S_FIN;
                    end
                    default: begin
                        n_state = S_FIN;
                    end
                endcase
            end
            S_DIVW: begin
                if (eng_rsp.done) begin
                    n_yt    = 32'(signed'({1'b0, r_year})) + yo;
                    n_mo    = r_neg ? (LAST_MONTH - rem12) : rem12;
                    n_tdd   = 5'd1;
                    n_state = S_YCHK;
                end
            end
            S_YCHK: begin
                // The target year must lie in 1..MAX_YEAR before any day count.
                if (r_yt < 32'sd1 || r_yt > 32'(MAX_YEAR)) begin
                    n_state = S_FIN;
                end else begin
                    n_req   = '{start: 1'b1, op: OP_DIY, arg: 30'(r_yt - 32'sd1)};
                    n_state = S_DAW;
                end
            end
            S_DAW: begin
                if (eng_rsp.done) begin
                    n_da    = eng_rsp.res;
                    n_req   = '{start: 1'b1, op: OP_DIY, arg: 30'(r_yt)};
                    n_state = S_DBW;
                end
            end
            S_DBW: begin
                if (eng_rsp.done) begin
                    // A year is leap exactly when it holds 366 days.
                    n_t = 32'(signed'({1'b0, r_da})) + 32'(month_start(r_mo))
                          + 32'(r_tdd)
                          + (((r_mo > FEBRUARY)
                              && (9'(eng_rsp.res - r_da) == DAYS_LONG_YEAR))
                             ? 32'sd1 : 32'sd0);
                    n_state = S_RANGE;
                end
            end
            S_RANGE: begin
                if (r_t < 32'sd1 || r_t > 32'(LAST_DAY)) begin
                    n_state = S_FIN;
                end else begin
                    n_lo    = 20'd0;
                    n_hi    = 20'(MAX_YEAR);
                    n_state = S_BS;
                end
            end
            S_BS: begin
                // Find the last year count whose total days fall short of the target.
                if (r_lo < r_hi) begin
                    n_mid   = mid_sum[20:1];
                    n_req   = '{start: 1'b1, op: OP_DIY, arg: 30'(mid_sum[20:1])};
                    n_state = S_BSW;
                end else begin
                    n_req   = '{start: 1'b1, op: OP_DIY, arg: 30'(r_lo)};
                    n_state = S_R1W;
                end
            end
            S_BSW: begin
                if (eng_rsp.done) begin
                    if (32'(signed'({1'b0, eng_rsp.res})) < r_t) begin
                        n_lo = r_mid;
                    end else begin
                        n_hi = r_mid - 20'd1;
                    end
                    n_state = S_BS;
                end
            end
            S_R1W: begin
                if (eng_rsp.done) begin
                    n_dlo   = eng_rsp.res;
                    n_rem   = 9'(r_t[28:0] - eng_rsp.res);
                    n_req   = '{start: 1'b1, op: OP_DIY, arg: 30'(r_lo) + 30'd1};
                    n_state = S_R2W;
                end
            end
            S_R2W: begin
                if (eng_rsp.done) begin
                    n_leap  = (span == DAYS_LONG_YEAR);
                    n_m     = 4'd0;
                    n_state = S_MON;
                end
            end
            S_MON: begin
                // One month is stepped over per cycle.
                if (r_m < LAST_MONTH && r_rem > 9'(len)) begin
                    n_rem = r_rem - 9'(len);
                    n_m   = r_m + 4'd1;
                end else begin
                    n_state = S_COMMIT;
                end
            end
            S_COMMIT: begin
                n_dn    = r_t[28:0];
                n_year  = r_lo + 20'd1;
                n_month = r_m;
                n_day   = r_rem[4:0];
                n_wd    = mod7(r_t[28:0]);
                n_ok    = 1'b1;
                n_state = S_FIN;
            end
            S_FIN: begin
                // Wait for the result register to be free, then report the date.
                if (!r_ov || !i_stall) begin
                    n_ov      = 1'b1;
                    n_o_ok    = r_ok;
                    n_o_year  = r_year;
                    n_o_month = r_month;
                    n_o_day   = r_day;
                    n_o_dn    = r_dn;
                    n_o_wd    = r_wd;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_valid      = r_ov;
    assign o_ok         = r_o_ok;
    assign o_year       = r_o_year;
    assign o_month      = r_o_month;
    assign o_day        = r_o_day;
    assign o_day_number = r_o_dn;
    assign o_weekday    = r_o_wd;

endmodule

/* hw/rtl/gdn_years.sv */
// Shared multiply engine: days in years 1..x, or floor division by 12.
// Depends on gdn_pkg.
module gdn_years
    import gdn_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_eng_req i_req,
    output t_eng_rsp o_rsp
);

    t_eng_st     r_st, n_st;
    logic        r_done, n_done;
    logic [29:0] r_x;
    logic [60:0] r_prod;
    logic [13:0] r_q100;
    logic [11:0] r_q400;
    logic [8:0]  r_q4000;
    logic [28:0] r_res;
    logic [30:0] mul_b;
    logic [60:0] mul_p;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= E_IDLE;
            r_done <= 1'b0;
        end else begin
            r_st   <= n_st;
            r_done <= n_done;
        end
    end

    always_comb begin
        n_st   = r_st;
        n_done = 1'b0;
        mul_b  = DAYS_PER_YEAR;
        case (r_st)
            E_IDLE: begin
                if (i_req.start) begin
                    n_st = (i_req.op == OP_DIY) ? E_Q100 : E_D12;
                end
            end
            E_Q100:  begin mul_b = RECIP_100;  n_st = E_Q400;  end
            E_Q400:  begin mul_b = RECIP_400;  n_st = E_Q4000; end
            E_Q4000: begin mul_b = RECIP_4000; n_st = E_M365;  end
            E_M365:  begin mul_b = DAYS_PER_YEAR; n_st = E_SUM; end
            E_SUM:   begin n_done = 1'b1;      n_st = E_IDLE;  end
            E_D12:   begin mul_b = RECIP_12;   n_st = E_D12R;  end
            E_D12R:  begin n_done = 1'b1;      n_st = E_IDLE;  end
            default: n_st = E_IDLE;
        endcase
        mul_p = 61'(r_x) * 61'(mul_b);
    end

    // A single multiplier serves every step; quotients are taken from
    // the product register in the state after the multiply.
    always_ff @(posedge i_clk) begin
        if (r_st == E_IDLE && i_req.start) begin
            r_x <= i_req.arg;
        end
        r_prod <= mul_p;
        if (r_st == E_Q400) begin
            r_q100 <= r_prod[40:27];
        end
        if (r_st == E_Q4000) begin
            r_q400 <= r_prod[40:29];
        end
        if (r_st == E_M365) begin
            r_q4000 <= r_prod[40:32];
        end
        if (r_st == E_SUM) begin
            r_res <= r_prod[28:0] + 29'(r_x[19:2]) - 29'(r_q100) + 29'(r_q400)
                     - 29'(r_q4000);
        end
        if (r_st == E_D12R) begin
            r_res <= 29'(r_prod[60:34]);
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.res  = r_res;

endmodule

/* test/gdn_checker.sv */
// Checker for the Gregorian day-number calendar: watches both channels, predicts each
// result from its own model of the date state, and counts mismatches. Depends on gdn_pkg.
module gdn_checker
    import gdn_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               o_stall,
    input  logic [2:0]         i_cmd,
    input  logic [19:0]        i_target_year,
    input  logic [3:0]         i_target_month,
    input  logic [4:0]         i_target_day,
    input  logic signed [29:0] i_amount,
    input  logic               o_valid,
    input  logic               i_stall,
    input  logic               o_ok,
    input  logic [19:0]        o_year,
    input  logic [3:0]         o_month,
    input  logic [4:0]         o_day,
    input  logic [28:0]        o_day_number,
    input  logic [2:0]         o_weekday,
    output int                 o_fail_count,
    output int                 o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic        ok;
        logic [19:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [28:0] day_number;
        logic [2:0]  weekday;
    } t_date_result;

    t_date_result expected_dates[$];
    longint       model_day;
    int           fail_count;

    assign o_fail_count = fail_count;
    assign o_pending    = expected_dates.size();

    function automatic bit is_long_year(longint y);
        if (y % 4000 == 0) return 0;
        if (y % 400 == 0) return 1;
        if (y % 100 == 0) return 0;
        return (y % 4) == 0;
    endfunction

    function automatic longint days_through(longint y);
        return y * 365 + y / 4 - y / 100 + y / 400 - y / 4000;
    endfunction

    function automatic longint month_len_of(int m, bit leap);
        int lens[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
        return (m == 1 && leap) ? 29 : lens[m];
    endfunction

    function automatic longint cumulative_days(int m);
        longint s;
        s = 0;
        for (int k = 0; k < m; k++) s += month_len_of(k, 0);
        return s;
    endfunction

    // Moves the model only when the target lies in the calendar's range.
    function automatic bit move_to_day(longint t);
        if (t < 1 || t > days_through(MAX_YEAR)) return 0;
        model_day = t;
        return 1;
    endfunction

    function automatic bit move_to_date(longint y, longint m, longint d);
        longint t;
        if (y < 1 || y > MAX_YEAR || m < 0 || m > 11) return 0;
        t = days_through(y - 1) + cumulative_days(int'(m)) + d;
        if (m > 1 && is_long_year(y)) t += 1;
        return move_to_day(t);
    endfunction

    function automatic void split_day(longint t, output longint y, output longint m,
                                      output longint d);
        longint lo, hi, mid, rem;
        lo = 0;
        hi = MAX_YEAR;
        while (lo < hi) begin
            mid = (lo + hi + 1) / 2;
            if (days_through(mid) < t) lo = mid;
            else hi = mid - 1;
        end
        rem = t - days_through(lo);
        y = lo + 1;
        m = 0;
        while (m < 11 && rem > month_len_of(int'(m), is_long_year(y))) begin
            rem -= month_len_of(int'(m), is_long_year(y));
            m++;
        end
        d = rem;
    endfunction

    function automatic t_date_result apply_command(logic [2:0] cmd, longint ty, longint tm,
                                                   longint td, longint amt);
        t_date_result r;
        longint y, m, d, mi, yo;
        bit ok;
        split_day(model_day, y, m, d);
        case (cmd)
            CMD_GOTO: ok = move_to_date(ty, tm, td);
            CMD_ADDD: ok = move_to_day(model_day + amt);
            CMD_ADDM: begin
                mi = m + amt;
                yo = mi / 12;
                mi = mi % 12;
                if (mi < 0) begin
                    yo -= 1;
                    mi += 12;
                end
                ok = move_to_date(y + yo, mi, 1);
            end
            CMD_ADDY: ok = move_to_date(y + amt, 0, 1);
            CMD_READ: ok = 1;
            default:  ok = 0;
        endcase
        split_day(model_day, y, m, d);
        r.ok         = ok;
        r.year       = 20'(y);
        r.month      = 4'(m);
        r.day        = 5'(d);
        r.day_number = 29'(model_day);
        r.weekday    = 3'(model_day % 7);
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_date_result got, want;
        if (!i_rst_n) begin
            model_day  = 1;
            fail_count <= 0;
            expected_dates.delete();
        end else begin
            if (i_valid && !o_stall) begin
                expected_dates.push_back(apply_command(i_cmd, longint'(i_target_year),
                    longint'(i_target_month), longint'(i_target_day), longint'(i_amount)));
            end
            if (o_valid && !i_stall) begin
                got = {o_ok, o_year, o_month, o_day, o_day_number, o_weekday};
                if (expected_dates.size() == 0) begin
                    if (fail_count < 10) $display("Unexpected result %p", got);
                    fail_count <= fail_count + 1;
                end else begin
                    want = expected_dates.pop_front();
                    if (got !== want) begin
                        if (fail_count < 10) $display("Mismatch: expected %p, got %p", want, got);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

/* test/tb_gregorian_day_number_calendar.sv */
// Testbench top for the Gregorian day-number calendar: drives commands with bursty timing,
// stalls results on its own pattern, reports the verdict. Depends on gdn_pkg, gdn_checker.
module tb_gregorian_day_number_calendar
    import gdn_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    logic               i_clk = 0;
    logic               i_rst_n = 0;
    logic               i_valid = 0;
    logic               o_stall;
    logic [2:0]         i_cmd = '0;
    logic [19:0]        i_target_year = '0;
    logic [3:0]         i_target_month = '0;
    logic [4:0]         i_target_day = '0;
    logic signed [29:0] i_amount = '0;
    logic               o_valid;
    logic               i_stall = 0;
    logic               o_ok;
    logic [19:0]        o_year;
    logic [3:0]         o_month;
    logic [4:0]         o_day;
    logic [28:0]        o_day_number;
    logic [2:0]         o_weekday;
    int                 fail_count;
    int                 pending;
    longint             cycle_count = 0;

    // The run is ended as failed if it exceeds the cycle limit.
    localparam longint CYCLE_LIMIT = 1000000;
    localparam int     RANDOM_ITEMS = 600;

    always #10 i_clk = ~i_clk;

    gregorian_day_number_calendar dut (.*);

    gdn_checker u_checker (.*, .o_fail_count(fail_count), .o_pending(pending));

    // The receiver alternates between runs of free flow and runs of random stalls.
    always @(negedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count[9]) i_stall <= 1'b0;
        else i_stall <= ($urandom_range(0, 3) == 0);
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Holds one item on the input channel until the block accepts it.
    task automatic send_command(logic [2:0] cmd, logic [19:0] ty, logic [3:0] tm,
                                logic [4:0] td, logic signed [29:0] amt);
        i_cmd          <= cmd;
        i_target_year  <= ty;
        i_target_month <= tm;
        i_target_day   <= td;
        i_amount       <= amt;
        i_valid        <= 1'b1;
        do @(posedge i_clk); while (o_stall);
        @(negedge i_clk);
    endtask

    task automatic send_random_command();
        int kind;
        logic [2:0] cmd;
        logic [19:0] ty;
        logic [3:0] tm;
        logic signed [29:0] amt;
        kind = $urandom_range(0, 99);
        ty = ($urandom_range(0, 3) == 0) ? 20'($urandom) : 20'($urandom_range(1, 999999));
        tm = ($urandom_range(0, 9) == 0) ? 4'($urandom) : 4'($urandom_range(0, 11));
        // Mostly small moves so that dates stay in range; occasionally any value at all.
        case ($urandom_range(0, 3))
            0:       amt = 30'($urandom);
            1:       amt = 30'(signed'($urandom_range(0, 200000)) - 100000);
            default: amt = 30'(signed'($urandom_range(0, 2000)) - 1000);
        endcase
        if (kind < 25) cmd = CMD_GOTO;
        else if (kind < 50) cmd = CMD_ADDD;
        else if (kind < 70) cmd = CMD_ADDM;
        else if (kind < 85) cmd = CMD_ADDY;
        else if (kind < 95) cmd = CMD_READ;
        else cmd = 3'($urandom_range(5, 7));
        send_command(cmd, ty, tm, 5'($urandom), amt);
    endtask

    initial begin
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: reset date, extremes of each field, leap rules and refused moves.
        send_command(CMD_READ, 20'd0, 4'd0, 5'd0, 30'sd0);
        send_command(CMD_ADDD, 20'd0, 4'd0, 5'd0, -30'sd1);
        send_command(CMD_GOTO, 20'd0, 4'd0, 5'd1, 30'sd0);
        send_command(CMD_GOTO, 20'd1, 4'd0, 5'd0, 30'sd0);
        send_command(CMD_GOTO, 20'd2000, 4'd12, 5'd1, 30'sd0);
        send_command(CMD_GOTO, 20'd2000, 4'd15, 5'd1, 30'sd0);
        send_command(CMD_GOTO, 20'd2000, 4'd1, 5'd29, 30'sd0);
        send_command(CMD_GOTO, 20'd1900, 4'd1, 5'd29, 30'sd0);
        send_command(CMD_GOTO, 20'd4000, 4'd1, 5'd29, 30'sd0);
        send_command(CMD_GOTO, 20'd2024, 4'd11, 5'd31, 30'sd0);
        send_command(CMD_GOTO, 20'd999999, 4'd11, 5'd31, 30'sd0);
        send_command(CMD_ADDD, 20'd0, 4'd0, 5'd0, 30'sd1);
        send_command(CMD_GOTO, 20'hFFFFF, 4'd0, 5'd1, 30'sd0);
        send_command(CMD_GOTO, 20'd999999, 4'd11, 5'd31, 30'sd0);
        send_command(CMD_ADDM, 20'd0, 4'd0, 5'd0, 30'sd1);
        send_command(CMD_ADDY, 20'd0, 4'd0, 5'd0, 30'sd1);
        send_command(CMD_ADDM, 20'd0, 4'd0, 5'd0, -30'sd13);
        send_command(CMD_ADDY, 20'd0, 4'd0, 5'd0, -30'sd999998);
        send_command(CMD_ADDM, 20'd0, 4'd0, 5'd0, -30'sd536870912);
        send_command(CMD_ADDY, 20'd0, 4'd0, 5'd0, 30'sd536870911);
        send_command(CMD_ADDD, 20'd0, 4'd0, 5'd0, 30'sd365241884);
        send_command(CMD_ADDD, 20'd0, 4'd0, 5'd0, -30'sd536870912);
        send_command(3'd5, 20'd0, 4'd0, 5'd0, 30'sd0);
        send_command(3'd7, 20'hFFFFF, 4'hF, 5'h1F, 30'sd536870911);

        // Random: bursts of back-to-back items separated by random gaps.
        for (int n = 0; n < RANDOM_ITEMS; ) begin
            int burst;
            int gap;
            burst = $urandom_range(1, 12);
            for (int b = 0; b < burst && n < RANDOM_ITEMS; b++, n++) send_random_command();
            gap = $urandom_range(0, 30);
            if (gap != 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        i_valid <= 1'b0;

        while (pending != 0) @(negedge i_clk);
        repeat (300) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule

/* sim.f */
hw/rtl/gdn_pkg.sv
hw/rtl/gdn_years.sv
hw/rtl/gregorian_day_number_calendar.sv
test/gdn_checker.sv
test/tb_gregorian_day_number_calendar.sv
